FILE: hw/rtl/ucd_pkg.sv
// ucd_pkg: shared types and constants for the UTF-8 code point decoder.
// No dependencies; imported by all ucd_* modules and the top level.
package ucd_pkg;

   localparam int CP_WIDTH      = 21;
   localparam int BYTE_WIDTH    = 8;
   localparam int QUEUE_DEPTH   = 4;
   localparam int RSP_DATA_BITS = ((CP_WIDTH + 7) / 8) * 8;

   // One queue entry per input byte that produces results.
   // pair: a malformed result precedes the one carried here.
   typedef struct packed {
      logic                pair;
      logic                bad;
      logic [CP_WIDTH-1:0] cp;
   } ucd_entry_type;

endpackage

FILE: hw/rtl/ucd_front.sv
// ucd_front: accepts bytes, tracks the pending sequence, classifies each byte
// and pushes the results it causes as one queue entry. Depends on ucd_pkg.
module ucd_front
   import ucd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_valid,
   input  logic [BYTE_WIDTH-1:0] byte_data,
   input  logic                  queue_full,
   output logic                  byte_ready,
   output logic                  push,
   output ucd_entry_type         push_entry
);

   typedef struct packed {
      logic                has_res;
      logic                bad;
      logic [CP_WIDTH-1:0] cp;
      logic [1:0]          rem;
      logic [CP_WIDTH-1:0] partial;
   } lead_type;

   // Decode a byte with no sequence pending.
   function automatic lead_type lead_decode(input logic [BYTE_WIDTH-1:0] b);
      lead_type r;
      r = '0;
      if (b == '0) begin
         r.has_res = 1'b0;
      end else if (b[7] == 1'b0) begin
         r.has_res = 1'b1;
         r.cp      = {{(CP_WIDTH-BYTE_WIDTH){1'b0}}, b};
      end else if (b[7:5] == 3'b110) begin
         r.rem     = 2'd1;
         r.partial = {{(CP_WIDTH-5){1'b0}}, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         r.rem     = 2'd2;
         r.partial = {{(CP_WIDTH-4){1'b0}}, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         r.rem     = 2'd3;
         r.partial = {{(CP_WIDTH-3){1'b0}}, b[2:0]};
      end else begin
         r.has_res = 1'b1;
         r.bad     = 1'b1;
      end
      return r;
   endfunction

   logic [CP_WIDTH-1:0] partial_ff, partial_in;
   logic [1:0]          remain_ff, remain_in;
   logic                accept;
   logic                is_cont;
   logic [CP_WIDTH-1:0] shifted;
   lead_type            lead;

   assign byte_ready = !queue_full;
   assign accept     = byte_valid && byte_ready;
   assign is_cont    = (byte_data[7:6] == 2'b10);
   assign shifted    = {partial_ff[CP_WIDTH-7:0], byte_data[5:0]};
   assign lead       = lead_decode(byte_data);

   always_comb begin
      partial_in = partial_ff;
      remain_in  = remain_ff;
      push       = 1'b0;
      push_entry = '0;
      if (accept) begin
         priority if (remain_ff == 2'd0) begin
            partial_in     = lead.partial;
            remain_in      = lead.rem;
            push           = lead.has_res;
            push_entry.bad = lead.bad;
            push_entry.cp  = lead.cp;
         end else if (is_cont) begin
            remain_in = remain_ff - 2'd1;
            if (remain_ff == 2'd1) begin
               partial_in    = '0;
               push          = 1'b1;
               push_entry.cp = shifted;
            end else begin
               partial_in = shifted;
            end
         end else begin
            // broken sequence: report it, then decode the byte as a lead
            partial_in      = lead.partial;
            remain_in       = lead.rem;
            push            = 1'b1;
            push_entry.pair = lead.has_res;
            push_entry.bad  = lead.has_res ? lead.bad : 1'b1;
            push_entry.cp   = lead.cp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         remain_ff  <= 2'd0;
      end else begin
         partial_ff <= partial_in;
         remain_ff  <= remain_in;
      end
   end

endmodule

FILE: hw/rtl/ucd_queue.sv
// ucd_queue: small register FIFO of result entries between front and back.
// Depends on ucd_pkg.
module ucd_queue
   import ucd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  ucd_entry_type push_entry,
   input  logic          pop,
   output logic          full,
   output logic          empty,
   output ucd_entry_type head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   ucd_entry_type slot_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: hw/rtl/ucd_back.sv
// ucd_back: expands queue entries into result transactions through an
// output register. Depends on ucd_pkg.
module ucd_back
   import ucd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  ucd_entry_type       head,
   input  logic                out_ready,
   output logic                pop,
   output logic                out_valid,
   output logic [CP_WIDTH-1:0] out_cp,
   output logic                out_bad,
   output logic                out_last
);

   logic                valid_ff, valid_in;
   logic                phase_ff, phase_in;
   logic [CP_WIDTH-1:0] cp_ff, cp_in;
   logic                bad_ff, bad_in;
   logic                last_ff, last_in;
   logic                load;

   assign load = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      cp_in    = cp_ff;
      bad_in   = bad_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = !empty;
         if (!empty) begin
            if (head.pair && !phase_ff) begin
               // leading malformed result of a broken sequence
               phase_in = 1'b1;
               cp_in    = '0;
               bad_in   = 1'b1;
               last_in  = 1'b0;
            end else begin
               phase_in = 1'b0;
               cp_in    = head.cp;
               bad_in   = head.bad;
               last_in  = 1'b1;
               pop      = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_ff   <= cp_in;
      bad_ff  <= bad_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_cp    = cp_ff;
   assign out_bad   = bad_ff;
   assign out_last  = last_ff;

endmodule

FILE: hw/rtl/utf8_codepoint_decoder.sv
// utf8_codepoint_decoder: one UTF-8 byte per transaction in, decoded code points out.
// A result is written into the entry queue on the edge that accepts its byte, then moves into
// the output register once that register is free; the second result of a pair follows it.
// Throughput: one byte per cycle unless the queue is full; one result per cycle while the
// receiver is ready; a byte with two results loads the output twice; the queue absorbs this.
// Reset: synchronous, active high; clears the pending sequence, the queue and the output valid.
module utf8_codepoint_decoder
   import ucd_pkg::*;
#(
   parameter int QDEPTH = QUEUE_DEPTH
)
(
   input  logic                     clock,
   input  logic                     reset,
   // input byte stream
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [BYTE_WIDTH-1:0]    req_tdata,   // [7:0] byte_in
   // result stream
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // [20:0] code_point, rest zero
   output logic                     rsp_tuser,   // [0] malformed
   output logic                     rsp_tlast    // last_of_run
);

   // front -> queue
   logic          push;
   ucd_entry_type push_entry;
   logic          queue_full;

   // queue -> back
   logic          pop;
   logic          queue_empty;
   ucd_entry_type head;

   logic [CP_WIDTH-1:0] out_cp;

   // Front end: sequence state and byte classification. Stalls only when
   // the queue is full, never on the result side directly.
   ucd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_data  (req_tdata),
      .queue_full (queue_full),
      .byte_ready (req_tready),
      .push       (push),
      .push_entry (push_entry)
   );

   // Entry queue: one entry per byte that produces results.
   ucd_queue #(
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head       (head)
   );

   // Back end: splits paired entries into two transactions, drives rsp_*.
   ucd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (queue_empty),
      .head      (head),
      .out_ready (rsp_tready),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_cp    (out_cp),
      .out_bad   (rsp_tuser),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {{(RSP_DATA_BITS-CP_WIDTH){1'b0}}, out_cp};

endmodule

FILE: sim/testbench.sv
// testbench: self-checking regression for utf8_codepoint_decoder.
// Streams UTF-8 bytes in with random gaps and stalls; a built-in decoder predicts the results.
// Depends on ucd_pkg and the utf8_codepoint_decoder RTL only.
`timescale 1ns / 100ps

module testbench;
   import ucd_pkg::*;

   // Bytes sent in the directed part, in order.
   localparam logic [7:0] DIRECTED_BYTES [24] = '{
      8'h00,                      // end of text with nothing pending: no result
      8'h01, 8'h7F,               // single-byte extremes
      8'h80, 8'hF8, 8'hFF,        // bytes that cannot lead a sequence
      8'hC0, 8'h80,               // overlong form, decodes to zero without error
      8'hDF, 8'hBF,               // largest two-byte value
      8'hEF, 8'hBF, 8'hBF,        // largest three-byte value
      8'hF7, 8'hBF, 8'hBF, 8'hBF, // all-ones four-byte value
      8'hC3, 8'h41,               // broken sequence, then ASCII: two results
      8'hE2, 8'h82, 8'h00,        // end of text mid-sequence
      8'hC2, 8'hFF                // broken sequence, then a bad lead: two errors
   };
   localparam int RANDOM_ITEMS = 900;
   localparam int IDLE_LIMIT   = 2000; // cycles without any transaction
   localparam int LONG_HOLD    = 300;  // receiver back-pressure stretch
   localparam int DRAIN_CYCLES = 10;

   // Decodes the byte stream the same way the block should and checks each result.
   class cp_tracker;
      typedef struct packed {
         logic [CP_WIDTH-1:0] cp;
         logic                bad;
         logic                last;
      } cp_result_type;

      logic [CP_WIDTH-1:0] partial_cp;
      logic [1:0]          cont_due;
      cp_result_type       pending_cps[$];
      int                  errors;
      int                  results_seen;

      function new();
         partial_cp   = '0;
         cont_due     = '0;
         errors       = 0;
         results_seen = 0;
      endfunction

      // Lead-byte decode with no sequence pending; returns 1 when it yields a result.
      function bit decode_lead(input logic [7:0] b, output cp_result_type r);
         r = '0;
         if (b == 8'h00) return 1'b0;
         if (b[7] == 1'b0) begin
            r = '{cp: CP_WIDTH'(b), bad: 1'b0, last: 1'b1};
            return 1'b1;
         end
         if (b[7:5] == 3'b110) begin
            partial_cp = CP_WIDTH'(b[4:0]);
            cont_due   = 2'd1;
            return 1'b0;
         end
         if (b[7:4] == 4'b1110) begin
            partial_cp = CP_WIDTH'(b[3:0]);
            cont_due   = 2'd2;
            return 1'b0;
         end
         if (b[7:3] == 5'b11110) begin
            partial_cp = CP_WIDTH'(b[2:0]);
            cont_due   = 2'd3;
            return 1'b0;
         end
         // continuation byte or 0xF8..0xFF with nothing pending
         r = '{cp: '0, bad: 1'b1, last: 1'b1};
         return 1'b1;
      endfunction

      // Called for every byte transaction accepted by the block.
      function void note_byte(input logic [7:0] b);
         cp_result_type r;
         if (cont_due == 2'd0) begin
            if (decode_lead(b, r)) pending_cps.push_back(r);
         end else if (b[7:6] == 2'b10) begin
            partial_cp = {partial_cp[CP_WIDTH-7:0], b[5:0]};
            cont_due   = cont_due - 2'd1;
            if (cont_due == 2'd0) begin
               pending_cps.push_back('{cp: partial_cp, bad: 1'b0, last: 1'b1});
               partial_cp = '0;
            end
         end else begin
            // broken sequence: flag it, then the byte starts over as a lead
            partial_cp = '0;
            cont_due   = 2'd0;
            if (decode_lead(b, r)) begin
               pending_cps.push_back('{cp: '0, bad: 1'b1, last: 1'b0});
               pending_cps.push_back(r);
            end else begin
               pending_cps.push_back('{cp: '0, bad: 1'b1, last: 1'b1});
            end
         end
      endfunction

      // Called for every result transaction accepted from the block.
      function void check_result(input logic [CP_WIDTH-1:0] cp, input logic bad,
                                 input logic last);
         cp_result_type want;
         results_seen++;
         if (pending_cps.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual cp=%h bad=%b last=%b",
                     $time, cp, bad, last);
            errors++;
            return;
         end
         want = pending_cps.pop_front();
         if (cp !== want.cp) begin
            $display("%0t: code_point mismatch: expected %h, actual %h", $time, want.cp, cp);
            errors++;
         end
         if (bad !== want.bad) begin
            $display("%0t: malformed mismatch: expected %b, actual %b", $time, want.bad, bad);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last_of_run mismatch: expected %b, actual %b",
                     $time, want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [BYTE_WIDTH-1:0]    req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // [20:0] code_point, rest zero
   logic                     rsp_tuser;   // [0] malformed
   logic                     rsp_tlast;   // last_of_run

   cp_tracker decoded = new();
   int        idle_cycles = 0;
   int        tx_calm = 0;   // sender: cycles left in a no-gap stretch
   int        rx_calm = 0;   // receiver: same for stalls
   bit        long_hold_done = 1'b0;

   utf8_codepoint_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mostly zero or short gaps, a few long ones, and now and then a stretch with none.
   function automatic int pick_gap(ref int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Lead byte for a sequence of the given length with random payload bits.
   function automatic logic [7:0] lead_for(input int len);
      logic [7:0] b;
      b = 8'($urandom);
      case (len)
         1: b = 8'($urandom_range(1, 127));
         2: b = {3'b110, b[4:0]};
         3: b = {4'b1110, b[3:0]};
         default: b = {5'b11110, b[2:0]};
      endcase
      return b;
   endfunction

   // One byte transaction: optional gap with valid low, then hold valid until accepted.
   // Inputs change only at the falling edge; tready is sampled at the rising edge.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap(tx_calm);
      @(negedge clock);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decoded.note_byte(b);
   endtask

   // Result sink: random stalls, plus one long hold-off so the queue fills and
   // the block has to push back on the sender.
   initial begin : result_sink
      int stall;
      @(negedge clock);
      forever begin
         stall = pick_gap(rx_calm);
         if (!long_hold_done && decoded.results_seen >= 150) begin
            stall          = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         repeat (stall) begin
            rsp_tready <= 1'b0;
            @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
      end
   end

   // Result checks at the rising edge, on the handshake.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         decoded.check_result(rsp_tdata[CP_WIDTH-1:0], rsp_tuser, rsp_tlast);
   end

   // Watchdog: give up once nothing has moved on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("utf8_codepoint_decoder regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [7:0] seq_q[$];
      logic [7:0] b;
      int         items_sent;
      int         r;
      int         len;
      int         n_cont;

      items_sent = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i]);

      // Random text: mostly well-formed characters, some truncated sequences,
      // raw noise bytes and end-of-text markers.
      while (items_sent < RANDOM_ITEMS) begin
         seq_q.delete();
         r = $urandom_range(0, 99);
         if (r < 65) begin
            len = $urandom_range(1, 4);
            seq_q.push_back(lead_for(len));
            repeat (len - 1) begin
               b = 8'($urandom);
               seq_q.push_back({2'b10, b[5:0]});
            end
         end else if (r < 80) begin
            len    = $urandom_range(2, 4);
            n_cont = $urandom_range(0, len - 2);
            seq_q.push_back(lead_for(len));
            repeat (n_cont) begin
               b = 8'($urandom);
               seq_q.push_back({2'b10, b[5:0]});
            end
            // terminator is anything but a continuation byte, often end of text
            b = 8'($urandom);
            if (b[7:6] == 2'b10) b[6] = 1'b1;
            if ($urandom_range(0, 3) == 0) b = 8'h00;
            seq_q.push_back(b);
         end else if (r < 90) begin
            seq_q.push_back(8'($urandom));
         end else begin
            seq_q.push_back(8'h00);
         end
         foreach (seq_q[i]) send_byte(seq_q[i]);
         items_sent += seq_q.size();
      end

      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain, then let the pipeline settle in case something stray comes out
      while (decoded.pending_cps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (decoded.errors == 0) begin
         $display("utf8_codepoint_decoder regression: pass");
      end else begin
         $display("utf8_codepoint_decoder regression: fail");
      end
      $finish;
   end

endmodule

FILE: utf8_codepoint_decoder.f
hw/rtl/ucd_pkg.sv
hw/rtl/ucd_front.sv
hw/rtl/ucd_queue.sv
hw/rtl/ucd_back.sv
hw/rtl/utf8_codepoint_decoder.sv
sim/testbench.sv
